[hw/rtl/jssp_pkg.sv]
// ----------------------------------------------------------------------------
// jssp_pkg
// Shared types, codes and constants of the JSON-subset stream parser.
// ----------------------------------------------------------------------------
package jssp_pkg;

  localparam int JSSP_MAX_DEPTH = 16;
  localparam int NEST_W         = 5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  typedef enum logic [9:0] {
    ST_START      = 10'b00_0000_0001,
    ST_KEY_OR_END = 10'b00_0000_0010,
    ST_IN_KEY     = 10'b00_0000_0100,
    ST_COLON      = 10'b00_0000_1000,
    ST_VALUE      = 10'b00_0001_0000,
    ST_ITEM_START = 10'b00_0010_0000,
    ST_IN_STRING  = 10'b00_0100_0000,
    ST_LIST_NEXT  = 10'b00_1000_0000,
    ST_OBJ_NEXT   = 10'b01_0000_0000,
    ST_DONE       = 10'b10_0000_0000
  } pstate_t;

  typedef enum logic [3:0] {
    EV_SKIP       = 4'd0,
    EV_OBJ_OPEN   = 4'd1,
    EV_OBJ_CLOSE  = 4'd2,
    EV_KEY_START  = 4'd3,
    EV_KEY_BYTE   = 4'd4,
    EV_KEY_END    = 4'd5,
    EV_COLON      = 4'd6,
    EV_VAL_START  = 4'd7,
    EV_VAL_BYTE   = 4'd8,
    EV_VAL_END    = 4'd9,
    EV_LIST_OPEN  = 4'd10,
    EV_ITEM_START = 4'd11,
    EV_ITEM_BYTE  = 4'd12,
    EV_ITEM_END   = 4'd13,
    EV_LIST_CLOSE = 4'd14,
    EV_COMMA      = 4'd15
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_FORMAT     = 2'd1,
    ERR_TOO_DEEP   = 2'd2,
    ERR_INCOMPLETE = 2'd3
  } err_t;

  // Parser control state besides the depth counter.
  typedef struct packed {
    pstate_t pst;
    logic    in_list;
    err_t    err;
  } ctl_t;

  // Per-byte result produced by the step logic.
  typedef struct packed {
    event_t            ev;
    logic [NEST_W-1:0] nest_depth;
    err_t              err;
    logic              ok;
  } res_t;

endpackage

[hw/rtl/jssp_in_if.sv]
// ----------------------------------------------------------------------------
// jssp_in_if
// Byte request channel: valid/ready handshake with document byte payload.
// ----------------------------------------------------------------------------
interface jssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hw/rtl/jssp_out_if.sv]
// ----------------------------------------------------------------------------
// jssp_out_if
// Result channel: valid/ready handshake with token event payload.
// ----------------------------------------------------------------------------
interface jssp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [7:0] byte_out;
  logic [4:0] nest_depth;
  logic [1:0] error_code;
  logic       doc_end;
  logic       doc_ok;

  modport source (output valid, output event_res, output byte_out, output nest_depth,
                  output error_code, output doc_end, output doc_ok, input ready);
  modport sink   (input valid, input event_res, input byte_out, input nest_depth,
                  input error_code, input doc_end, input doc_ok, output ready);
endinterface

[hw/rtl/json_subset_stream_parser.sv]
// ----------------------------------------------------------------------------
// json_subset_stream_parser
// Byte-serial tokenizer and validator for a small JSON subset.
// ----------------------------------------------------------------------------
// The parser takes one document byte per request on din and returns exactly
// one result per byte on dout: the token event, the byte itself, the object
// nesting depth below the root and the sticky error code. The parse state
// register and the result register are the only stages, so a new byte is
// accepted every cycle as long as dout is taken or empty. The result is valid
// in the cycle after the byte is accepted. The result for the byte flagged
// last_byte carries doc_end, doc_ok when the document closed with no error,
// or error code "incomplete" when it had no error but did not close; the
// parser then resets itself for the next document. Whitespace is dropped
// everywhere, including inside strings, and an error freezes the parse until
// the end of the document. MAX_DEPTH bounds nested objects; an opening brace
// beyond it reports "nesting too deep".
module json_subset_stream_parser import jssp_pkg::*; #(
  parameter int MAX_DEPTH = JSSP_MAX_DEPTH
) (
  input logic        clk,
  input logic        rst,
  jssp_in_if.sink    din,
  jssp_out_if.source dout
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  // parser state
  ctl_t               ctl;
  logic [DEPTH_W-1:0] depth;
  ctl_t               ctl_next;
  logic [DEPTH_W-1:0] depth_next;
  res_t               res;

  // result register
  logic       out_valid;
  res_t       out_res;
  logic [7:0] out_byte;
  logic       out_last;

  logic accept;

  // Take a new request whenever the result register is empty or being drained.
  assign din.ready = !out_valid || dout.ready;
  assign accept    = din.valid && din.ready;

  jssp_step #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_step (
    .data_byte  (din.data_byte),
    .last_byte  (din.last_byte),
    .ctl        (ctl),
    .depth      (depth),
    .ctl_next   (ctl_next),
    .depth_next (depth_next),
    .res        (res)
  );

  // Advance the parser only on accepted bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.pst     <= ST_START;
      ctl.in_list <= 1'b0;
      ctl.err     <= ERR_NONE;
      depth       <= '0;
    end else if (accept) begin
      ctl   <= ctl_next;
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res  <= res;
      out_byte <= din.data_byte;
      out_last <= din.last_byte;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.event_res  = out_res.ev;
  assign dout.byte_out   = out_byte;
  assign dout.nest_depth = out_res.nest_depth;
  assign dout.error_code = out_res.err;
  assign dout.doc_end    = out_last;
  assign dout.doc_ok     = out_res.ok;

  // Depth never passes the configured limit.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth above limit");

  // A clean document report implies end of document and no error.
  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.ok) |-> (out_last && out_res.err == ERR_NONE))
    else $error("doc_ok with error or not at end");

  // Incomplete is only reported on the last byte.
  a_incomplete_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.err == ERR_INCOMPLETE) |-> out_last)
    else $error("incomplete reported before end of document");

  // The last byte returns the parser to its start state.
  a_reset_on_last: assert property (@(posedge clk) disable iff (rst)
    (accept && din.last_byte) |=>
      (ctl.pst == ST_START && depth == '0 && ctl.err == ERR_NONE && !ctl.in_list))
    else $error("parser not restarted after last byte");

  // After an error the parse state is frozen until the document ends.
  a_error_freeze: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.err != ERR_NONE && !din.last_byte) |=>
      ($stable(ctl) && $stable(depth)))
    else $error("parser state moved after an error");

  // A result waiting on a stalled sink is not overwritten.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !dout.ready) |=> (out_valid && $stable(out_res) && $stable(out_byte)))
    else $error("stalled result changed");

endmodule

[hw/rtl/jssp_step.sv]
// ----------------------------------------------------------------------------
// jssp_step
// Combinational parse step: next state, token event and status for one byte.
// ----------------------------------------------------------------------------
module jssp_step import jssp_pkg::*; #(
  parameter  int MAX_DEPTH = JSSP_MAX_DEPTH,
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  ctl_t               ctl,
  input  logic [DEPTH_W-1:0] depth,
  output ctl_t               ctl_next,
  output logic [DEPTH_W-1:0] depth_next,
  output res_t               res
);

  localparam logic [DEPTH_W-1:0] DepthLimit = DEPTH_W'(MAX_DEPTH);

  ctl_t               adv;
  logic [DEPTH_W-1:0] adv_depth;
  event_t             ev;
  logic               bad;
  logic               ws;
  logic               done_ok;

  assign ws = (data_byte == CH_TAB) || (data_byte == CH_LF) ||
              (data_byte == CH_CR)  || (data_byte == CH_SPACE);

  always_comb begin
    adv       = ctl;
    adv_depth = depth;
    ev        = EV_SKIP;
    bad       = 1'b0;
    if (ctl.err == ERR_NONE && !ws) begin
      bad = 1'b1;
      case (ctl.pst)
        ST_START: begin
          if (data_byte == CH_LBRACE) begin
            adv.pst = ST_KEY_OR_END; ev = EV_OBJ_OPEN; bad = 1'b0;
          end
        end
        ST_KEY_OR_END, ST_OBJ_NEXT: begin
          if (data_byte == CH_QUOTE && ctl.pst == ST_KEY_OR_END) begin
            adv.pst = ST_IN_KEY; ev = EV_KEY_START; bad = 1'b0;
          end else if (data_byte == CH_COMMA && ctl.pst == ST_OBJ_NEXT) begin
            adv.pst = ST_KEY_OR_END; ev = EV_COMMA; bad = 1'b0;
          end else if (data_byte == CH_RBRACE) begin
            // close one level, or finish the document at the root
            ev  = EV_OBJ_CLOSE;
            bad = 1'b0;
            if (depth == '0) begin
              adv.pst = ST_DONE;
            end else begin
              adv.pst   = ST_OBJ_NEXT;
              adv_depth = depth - 1'b1;
            end
          end
        end
        ST_IN_KEY: begin
          bad = 1'b0;
          if (data_byte == CH_QUOTE) begin
            adv.pst = ST_COLON; ev = EV_KEY_END;
          end else begin
            ev = EV_KEY_BYTE;
          end
        end
        ST_COLON: begin
          if (data_byte == CH_COLON) begin
            adv.pst = ST_VALUE; ev = EV_COLON; bad = 1'b0;
          end
        end
        ST_VALUE: begin
          if (data_byte == CH_QUOTE) begin
            adv.in_list = 1'b0; adv.pst = ST_IN_STRING; ev = EV_VAL_START; bad = 1'b0;
          end else if (data_byte == CH_LBRACK) begin
            adv.in_list = 1'b1; adv.pst = ST_ITEM_START; ev = EV_LIST_OPEN; bad = 1'b0;
          end else if (data_byte == CH_LBRACE) begin
            bad = 1'b0;
            if (depth >= DepthLimit) begin
              adv.err = ERR_TOO_DEEP;
            end else begin
              adv_depth = depth + 1'b1;
              adv.pst   = ST_KEY_OR_END;
              ev        = EV_OBJ_OPEN;
            end
          end
        end
        ST_ITEM_START: begin
          if (data_byte == CH_QUOTE) begin
            adv.pst = ST_IN_STRING; ev = EV_ITEM_START; bad = 1'b0;
          end
        end
        ST_IN_STRING: begin
          bad = 1'b0;
          if (data_byte == CH_QUOTE) begin
            adv.pst = ctl.in_list ? ST_LIST_NEXT : ST_OBJ_NEXT;
            ev      = ctl.in_list ? EV_ITEM_END : EV_VAL_END;
          end else begin
            ev = ctl.in_list ? EV_ITEM_BYTE : EV_VAL_BYTE;
          end
        end
        ST_LIST_NEXT: begin
          if (data_byte == CH_COMMA) begin
            adv.pst = ST_ITEM_START; ev = EV_COMMA; bad = 1'b0;
          end else if (data_byte == CH_RBRACK) begin
            adv.in_list = 1'b0; adv.pst = ST_OBJ_NEXT; ev = EV_LIST_CLOSE; bad = 1'b0;
          end
        end
        default: begin
          bad = 1'b1;
        end
      endcase
      if (bad) begin
        adv       = ctl;
        adv_depth = depth;
        adv.err   = ERR_FORMAT;
        ev        = EV_SKIP;
      end
    end
  end

  assign done_ok = (adv.err == ERR_NONE) && (adv.pst == ST_DONE);

  always_comb begin
    res.ev         = ev;
    res.nest_depth = NEST_W'(adv_depth);
    res.err        = adv.err;
    res.ok         = last_byte && done_ok;
    if (last_byte && adv.err == ERR_NONE && !done_ok) begin
      res.err = ERR_INCOMPLETE;
    end
    // the last byte returns the parser to its start state
    if (last_byte) begin
      ctl_next.pst     = ST_START;
      ctl_next.in_list = 1'b0;
      ctl_next.err     = ERR_NONE;
      depth_next       = '0;
    end else begin
      ctl_next   = adv;
      depth_next = adv_depth;
    end
  end

endmodule
